/* hdl/arm_subset_instruction_execute_defines.svh */
// Assertion macros shared by the instruction execute block.
`ifndef ARM_SUBSET_INSTRUCTION_EXECUTE_DEFINES_SVH
`define ARM_SUBSET_INSTRUCTION_EXECUTE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ARSIE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARSIE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/arsie_pkg.sv */
// Types and constants of the instruction execute block.
`timescale 1ns / 1ps
package arsie_pkg;

	// Condition codes that are honored.
	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;

	// Data-processing opcodes.
	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_EOR = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_RSB = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_ADC = 4'd5;
	localparam logic [3:0] OP_SBC = 4'd6;
	localparam logic [3:0] OP_RSC = 4'd7;
	localparam logic [3:0] OP_TST = 4'd8;
	localparam logic [3:0] OP_TEQ = 4'd9;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_CMN = 4'd11;
	localparam logic [3:0] OP_ORR = 4'd12;
	localparam logic [3:0] OP_MOV = 4'd13;
	localparam logic [3:0] OP_BIC = 4'd14;
	localparam logic [3:0] OP_MVN = 4'd15;

	// Instruction classes from bits 27:26.
	localparam logic [1:0] CLS_DP  = 2'd0;
	localparam logic [1:0] CLS_LS  = 2'd1;
	localparam logic [1:0] CLS_BR  = 2'd2;
	localparam logic [1:0] CLS_SWI = 2'd3;

	// Shift types.
	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	localparam logic [3:0] REG_PC   = 4'd15;
	localparam logic [3:0] REG_LR   = 4'd14;
	localparam logic [7:0] SWI_HALT = 8'd10;

	// Read port order of the register file.
	localparam int PORT_RN = 0;
	localparam int PORT_RD = 1;
	localparam int PORT_RS = 2;
	localparam int PORT_RM = 3;
	localparam int NUM_PORTS = 4;

	// Register file write.
	typedef struct packed {
		logic        en;
		logic [3:0]  idx;
		logic [31:0] data;
	} arsie_wb_t;

	// Architectural state kept outside the register file.
	typedef struct packed {
		logic [31:0] pc;
		logic [3:0]  nzcv;
		logic        ld_pend;
		logic [3:0]  ld_dest;
		logic        ld_byte;
		logic        halted;
	} arsie_state_t;

	// Result item, next_fetch_address in the lowest bits.
	typedef struct packed {
		logic        is_halted;
		logic [3:0]  flags_now;
		logic        was_executed;
		logic [31:0] mem_write_data;
		logic [31:0] mem_address;
		logic        mem_is_byte;
		logic        mem_is_write;
		logic        mem_request;
		logic [31:0] next_fetch_address;
	} arsie_result_t;

endpackage

/* hdl/arsie_regfile.sv */
// Register file R0..R14: replicated synchronous memory with valid bits and forwarding.
`timescale 1ns / 1ps
module arsie_regfile
	import arsie_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [NUM_PORTS-1:0][3:0]   raddr,
	input  arsie_wb_t                   wb,
	output logic [NUM_PORTS-1:0][31:0]  rdata
);

	logic [31:0] mem [NUM_PORTS][16];
	logic [NUM_PORTS-1:0][31:0] rdata_q;
	logic [NUM_PORTS-1:0][3:0]  raddr_q;
	logic [15:0] valid_q;
	arsie_wb_t   fwd_q;

	// One copy per read port, all written together.
	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PORTS; p++) begin
			if (wb.en) begin
				mem[p][wb.idx] <= wb.data;
			end
			if (rd_en) begin
				rdata_q[p] <= mem[p][raddr[p]];
				raddr_q[p] <= raddr[p];
			end
		end
	end

	// Valid bits stand for the all-zero reset; last write is kept for forwarding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fwd_q   <= '0;
		end else if (wb.en) begin
			valid_q[wb.idx] <= 1'b1;
			fwd_q           <= wb;
		end
	end

	// A read that met a write to the same entry takes the written value.
	always_comb begin
		for (int p = 0; p < NUM_PORTS; p++) begin
			if (fwd_q.en && fwd_q.idx == raddr_q[p]) begin
				rdata[p] = fwd_q.data;
			end else if (valid_q[raddr_q[p]]) begin
				rdata[p] = rdata_q[p];
			end else begin
				rdata[p] = '0;
			end
		end
	end

endmodule

/* hdl/arsie_exec.sv */
// Execute stage: condition test, shifter, adder, multiplier, branch and load/store.
`timescale 1ns / 1ps
module arsie_exec
	import arsie_pkg::*;
(
	input  logic                        kind,
	input  logic [31:0]                 inst,
	input  logic [31:0]                 load_word,
	input  logic [NUM_PORTS-1:0][31:0]  rf_data,
	input  arsie_state_t                st,
	output arsie_state_t                st_next,
	output arsie_wb_t                   wb,
	output arsie_result_t               res
);

	// Barrel shifter, returns {carry, value}.
	function automatic logic [32:0] barrel(input logic [31:0] v, input logic [1:0] typ,
			input logic [7:0] amt_in, input logic by_reg, input logic cin);
		logic [7:0]  amt;
		logic [32:0] t;
		logic [63:0] w;
		logic [32:0] r;
		amt = amt_in;
		r = {cin, v};
		if (!by_reg && amt == 8'd0) begin
			amt = 8'd32;
		end
		if (!by_reg && amt_in == 8'd0 && typ == SH_LSL) begin
			r = {cin, v};
		end else if (!by_reg && amt_in == 8'd0 && typ == SH_ROR) begin
			r = {v[0], cin, v[31:1]};
		end else if (amt == 8'd0) begin
			r = {cin, v};
		end else begin
			case (typ)
				SH_LSL: begin
					t = {1'b0, v} << amt[4:0];
					if (amt < 8'd32) r = t;
					else if (amt == 8'd32) r = {v[0], 32'd0};
					else r = 33'd0;
				end
				SH_LSR: begin
					t = {v, 1'b0} >> amt[4:0];
					if (amt < 8'd32) r = {t[0], t[32:1]};
					else if (amt == 8'd32) r = {v[31], 32'd0};
					else r = 33'd0;
				end
				SH_ASR: begin
					t = 33'($signed({v, 1'b0}) >>> amt[4:0]);
					if (amt < 8'd32) r = {t[0], t[32:1]};
					else r = {v[31], {32{v[31]}}};
				end
				default: begin
					w = {v, v} >> amt[4:0];
					if (amt[4:0] == 5'd0) r = {v[31], v};
					else r = {w[31], w[31:0]};
				end
			endcase
		end
		return r;
	endfunction

	logic [31:0] pc8, pc4, rn_v, rd_v, rs_v, rm_v;
	logic        n, z, c, v, pass;
	logic [3:0]  opc;
	logic [32:0] sh_dp, sh_ls, sum;
	logic [31:0] add_a, add_b, alu_r, off, addr, br_off, mul_r, ld_d;
	logic        add_ci, alu_c, alu_v, is_logic;

	// Operand 15 reads as the instruction address plus 8.
	assign pc8  = st.pc + 32'd8;
	assign pc4  = st.pc + 32'd4;
	assign rn_v = (inst[19:16] == REG_PC) ? pc8 : rf_data[PORT_RN];
	assign rd_v = (inst[15:12] == REG_PC) ? pc8 : rf_data[PORT_RD];
	assign rs_v = (inst[11:8]  == REG_PC) ? pc8 : rf_data[PORT_RS];
	assign rm_v = (inst[3:0]   == REG_PC) ? pc8 : rf_data[PORT_RM];

	assign {n, z, c, v} = st.nzcv;
	assign opc = inst[24:21];

	// Condition test.
	always_comb begin
		unique case (inst[31:28])
			COND_EQ: pass = z;
			COND_NE: pass = !z;
			COND_GE: pass = (n == v);
			COND_LT: pass = (n != v);
			COND_GT: pass = !z && (n == v);
			COND_LE: pass = z || (n != v);
			COND_AL: pass = 1'b1;
			default: pass = 1'b0;
		endcase
	end

	// Shifter operands.
	always_comb begin
		if (inst[25]) begin
			sh_dp = barrel({24'd0, inst[7:0]}, SH_ROR, {3'd0, inst[11:8], 1'b0}, 1'b1, c);
		end else if (inst[4]) begin
			sh_dp = barrel(rm_v, inst[6:5], rs_v[7:0], 1'b1, c);
		end else begin
			sh_dp = barrel(rm_v, inst[6:5], {3'd0, inst[11:7]}, 1'b0, c);
		end
		sh_ls = barrel(rm_v, inst[6:5], {3'd0, inst[11:7]}, 1'b0, c);
	end

	// Adder operand selection and logic results.
	always_comb begin
		add_a = rn_v;
		add_b = sh_dp[31:0];
		add_ci = 1'b0;
		is_logic = 1'b0;
		alu_r = '0;
		case (opc)
			OP_SUB, OP_CMP: begin add_b = ~sh_dp[31:0]; add_ci = 1'b1; end
			OP_RSB: begin add_a = sh_dp[31:0]; add_b = ~rn_v; add_ci = 1'b1; end
			OP_ADD, OP_CMN: add_ci = 1'b0;
			OP_ADC: add_ci = c;
			OP_SBC: begin add_b = ~sh_dp[31:0]; add_ci = c; end
			OP_RSC: begin add_a = sh_dp[31:0]; add_b = ~rn_v; add_ci = c; end
			OP_AND, OP_TST: begin is_logic = 1'b1; alu_r = rn_v & sh_dp[31:0]; end
			OP_EOR, OP_TEQ: begin is_logic = 1'b1; alu_r = rn_v ^ sh_dp[31:0]; end
			OP_ORR: begin is_logic = 1'b1; alu_r = rn_v | sh_dp[31:0]; end
			OP_MOV: begin is_logic = 1'b1; alu_r = sh_dp[31:0]; end
			default: begin is_logic = 1'b1; alu_r = ~sh_dp[31:0]; end
		endcase
		sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};
		if (!is_logic) alu_r = sum[31:0];
		alu_c = is_logic ? sh_dp[32] : sum[32];
		alu_v = is_logic ? v : (~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31]));
	end

	// Address, branch target, multiply and load data.
	assign off    = inst[25] ? sh_ls[31:0] : {20'd0, inst[11:0]};
	assign addr   = inst[23] ? rn_v + off : rn_v - off;
	assign br_off = {{6{inst[23]}}, inst[23:0], 2'b00};
	assign mul_r  = rm_v * rs_v + (inst[21] ? rd_v : 32'd0);
	assign ld_d   = st.ld_byte ? {24'd0, load_word[7:0]} : load_word;

	// Instruction effect on state and result.
	always_comb begin
		st_next = st;
		wb = '0;
		res = '0;
		if (st.halted) begin
			res.next_fetch_address = st.pc;
			res.flags_now = st.nzcv;
			res.is_halted = 1'b1;
		end else begin
			if (kind) begin
				if (st.ld_pend) begin
					wb = '{en: 1'b1, idx: st.ld_dest, data: ld_d};
					st_next.ld_pend = 1'b0;
					res.was_executed = 1'b1;
				end
			end else begin
				st_next.pc = pc4;
				if (pass) begin
					case (inst[27:26])
						CLS_SWI: begin
							if (inst[25:24] == 2'b11 && inst[7:0] == SWI_HALT) begin
								st_next.halted = 1'b1;
								res.was_executed = 1'b1;
							end
						end
						CLS_BR: begin
							if (inst[25]) begin
								if (inst[24]) wb = '{en: 1'b1, idx: REG_LR, data: pc4};
								st_next.pc = pc8 + br_off;
								res.was_executed = 1'b1;
							end
						end
						CLS_LS: begin
							res.mem_request = 1'b1;
							res.mem_is_byte = inst[22];
							res.mem_address = addr;
							res.was_executed = 1'b1;
							if (inst[20]) begin
								st_next.ld_pend = 1'b1;
								st_next.ld_dest = inst[15:12];
								st_next.ld_byte = inst[22];
							end else begin
								res.mem_is_write = 1'b1;
								res.mem_write_data = inst[22] ? {24'd0, rd_v[7:0]} : rd_v;
							end
						end
						default: begin
							if (!inst[25] && inst[4] && inst[7]) begin
								if (inst[27:22] == 6'd0) begin
									wb = '{en: 1'b1, idx: inst[19:16], data: mul_r};
									if (inst[20]) st_next.nzcv = {mul_r[31], mul_r == 32'd0, c, v};
									res.was_executed = 1'b1;
								end
							end else if (opc != OP_BIC) begin
								if (opc < OP_TST || opc > OP_CMN) begin
									wb = '{en: 1'b1, idx: inst[15:12], data: alu_r};
								end
								if (inst[20] || (opc >= OP_TST && opc <= OP_CMN)) begin
									st_next.nzcv = {alu_r[31], alu_r == 32'd0, alu_c, alu_v};
								end
								res.was_executed = 1'b1;
							end
						end
					endcase
				end
			end
			// A write to R15 redirects the program counter.
			if (wb.en && wb.idx == REG_PC) begin
				st_next.pc = wb.data;
				wb.en = 1'b0;
			end
			res.next_fetch_address = st_next.pc;
			res.flags_now = st_next.nzcv;
			res.is_halted = st_next.halted;
		end
	end

endmodule

/* hdl/arm_subset_instruction_execute.sv */
// Top level of the ARM-style instruction execute block.
`timescale 1ns / 1ps
`include "arm_subset_instruction_execute_defines.svh"
// The block takes one item per clock while the output is not stalled. An accepted item reads
// its source registers from the register file memory at once; it executes in the following
// cycle, writes back and places its result in the output register. The write of one item is
// forwarded to the reads of the next. Reset clears the register file through per-entry valid
// bits, so no clearing pass follows reset. A stalled output holds the pipeline.
module arm_subset_instruction_execute
	import arsie_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [31:0]  cfg_wdata,      // start_address
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,        // instruction_word, load_word
	input  logic         s_tuser,        // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata         // next_fetch_address, mem_request, mem_is_write,
	                                     // mem_is_byte, mem_address, mem_write_data,
	                                     // was_executed, flags_now, is_halted, zero pad
);

	logic          v_s1, kind_s1, accept, fire1;
	logic [31:0]   inst_s1, ldw_s1;
	logic [NUM_PORTS-1:0][3:0]  raddr;
	logic [NUM_PORTS-1:0][31:0] rf_data;
	arsie_state_t  st_q, st_next;
	arsie_wb_t     wb;
	arsie_result_t res, out_q;

	// Handshake: the execute stage moves when the output register can take its result.
	assign fire1    = v_s1 && (!m_tvalid || m_tready);
	assign s_tready = !v_s1 || fire1;
	assign accept   = s_tvalid && s_tready;

	// Register read addresses come straight from the arriving instruction.
	assign raddr[PORT_RN] = s_tdata[19:16];
	assign raddr[PORT_RD] = s_tdata[15:12];
	assign raddr[PORT_RS] = s_tdata[11:8];
	assign raddr[PORT_RM] = s_tdata[3:0];

	arsie_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.raddr  (raddr),
		.wb     (fire1 ? wb : '0),
		.rdata  (rf_data)
	);

	arsie_exec u_exec (
		.kind      (kind_s1),
		.inst      (inst_s1),
		.load_word (ldw_s1),
		.rf_data   (rf_data),
		.st        (st_q),
		.st_next   (st_next),
		.wb        (wb),
		.res       (res)
	);

	// Stage 1 payload and output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			inst_s1 <= s_tdata[31:0];
			ldw_s1  <= s_tdata[63:32];
			kind_s1 <= s_tuser;
		end
		if (fire1) begin
			out_q <= res;
		end
	end

	// Control, state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			m_tvalid <= 1'b0;
			st_q     <= '0;
		end else begin
			if (accept) v_s1 <= 1'b1;
			else if (fire1) v_s1 <= 1'b0;
			if (fire1) begin
				m_tvalid <= 1'b1;
				st_q     <= st_next;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_wen) st_q.pc <= cfg_wdata;
		end
	end

	assign m_tdata = {7'd0, out_q};

	`ARSIE_ASSERT_NEXT(a_halt_sticks, st_q.halted, st_q.halted, "halt mark was cleared")
	`ARSIE_ASSERT_IMPL(a_no_pc_write, fire1 && wb.en, wb.idx != REG_PC, "write to R15 in file")
	`ARSIE_ASSERT_IMPL(a_no_overrun, accept && v_s1, fire1, "stage 1 overwritten")

endmodule

/* dv/tb_arm_subset_instruction_execute.sv */
// Self-checking testbench for the ARM-style instruction execute block.
`timescale 1ns / 1ps
module tb_arm_subset_instruction_execute;
	import arsie_pkg::*;

	// Architectural model of the execute block with a queue of expected results.
	class exec_scoreboard;
		bit [31:0] regs [15];
		bit [31:0] pc;
		bit [3:0]  nzcv;
		bit        ld_pend;
		bit [3:0]  ld_dest;
		bit        ld_byte;
		bit        halted;
		arsie_result_t expected_q [$];
		int        errors;
		int        checked;
		int        executed;
		int        mem_ops;

		function void load_start(bit [31:0] addr);
			pc = addr;
		endfunction

		function bit [31:0] read_reg(bit [3:0] idx, bit [31:0] pc8);
			return (idx == REG_PC) ? pc8 : regs[idx];
		endfunction

		function void write_reg(bit [3:0] idx, bit [31:0] val, inout bit [31:0] next_pc);
			if (idx == REG_PC)
				next_pc = val;
			else
				regs[idx] = val;
		endfunction

		// Barrel shifter with its carry-out.
		function bit [31:0] shifter(bit [31:0] v, bit [1:0] ty, int unsigned amt, bit by_reg,
				bit cin, output bit cout);
			int unsigned a;
			if (!by_reg && amt == 0) begin
				if (ty == SH_LSL) begin
					cout = cin;
					return v;
				end
				if (ty == SH_ROR) begin
					cout = v[0];
					return {cin, v[31:1]};
				end
				amt = 32;
			end
			if (amt == 0) begin
				cout = cin;
				return v;
			end
			case (ty)
				SH_LSL: begin
					if (amt < 32) begin
						cout = v[32 - amt];
						return v << amt;
					end
					cout = (amt == 32) ? v[0] : 1'b0;
					return 32'd0;
				end
				SH_LSR: begin
					if (amt < 32) begin
						cout = v[amt - 1];
						return v >> amt;
					end
					cout = (amt == 32) ? v[31] : 1'b0;
					return 32'd0;
				end
				SH_ASR: begin
					if (amt >= 32) begin
						cout = v[31];
						return {32{v[31]}};
					end
					cout = v[amt - 1];
					return $signed(v) >>> amt;
				end
				default: begin
					a = amt % 32;
					if (a == 0) begin
						cout = v[31];
						return v;
					end
					cout = v[a - 1];
					return (v >> a) | (v << (32 - a));
				end
			endcase
		endfunction

		function bit [31:0] add_carry(bit [31:0] a, bit [31:0] b, bit cin, output bit c,
				output bit v);
			bit [32:0] s;
			s = {1'b0, a} + {1'b0, b} + cin;
			c = s[32];
			v = ~(a[31] ^ b[31]) & (a[31] ^ s[31]);
			return s[31:0];
		endfunction

		function bit cond_ok(bit [3:0] cond);
			case (cond)
				COND_EQ: return nzcv[2];
				COND_NE: return !nzcv[2];
				COND_GE: return nzcv[3] == nzcv[0];
				COND_LT: return nzcv[3] != nzcv[0];
				COND_GT: return !nzcv[2] && nzcv[3] == nzcv[0];
				COND_LE: return nzcv[2] || nzcv[3] != nzcv[0];
				COND_AL: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void set_nzcv(bit [31:0] r, bit c, bit v);
			nzcv = {r[31], r == 32'd0, c, v};
		endfunction

		// Work out the result of one accepted transaction and queue it.
		function void note_input(bit kind, bit [31:0] inst, bit [31:0] ld_word);
			arsie_result_t res;
			bit [31:0] pc8, next_pc, addr, wdata, base, off, rn, op2, r, d;
			bit req, wr, byte_acc, done, cf, vf, c, v, sc, dummy;
			bit [3:0] opc;
			int unsigned amt;
			res = '0;
			if (halted) begin
				res.next_fetch_address = pc;
				res.flags_now = nzcv;
				res.is_halted = 1'b1;
				expected_q.push_back(res);
				return;
			end
			req = 0; wr = 0; byte_acc = 0; addr = 0; wdata = 0; done = 0;
			next_pc = pc;
			if (kind) begin
				if (ld_pend) begin
					d = ld_byte ? {24'd0, ld_word[7:0]} : ld_word;
					write_reg(ld_dest, d, next_pc);
					ld_pend = 0;
					done = 1;
				end
			end else begin
				pc8 = pc + 8;
				next_pc = pc + 4;
				cf = nzcv[1];
				vf = nzcv[0];
				if (cond_ok(inst[31:28])) begin
					case (inst[27:26])
						CLS_SWI: begin
							if (inst[27:24] == 4'hF && inst[7:0] == SWI_HALT) begin
								halted = 1;
								done = 1;
							end
						end
						CLS_BR: begin
							if (inst[25]) begin
								off = {{6{inst[23]}}, inst[23:0], 2'b00};
								if (inst[24])
									regs[REG_LR] = pc + 4;
								next_pc = pc8 + off;
								done = 1;
							end
						end
						CLS_LS: begin
							base = read_reg(inst[19:16], pc8);
							if (inst[25])
								off = shifter(read_reg(inst[3:0], pc8), inst[6:5], inst[11:7],
									1'b0, cf, dummy);
							else
								off = {20'd0, inst[11:0]};
							addr = inst[23] ? base + off : base - off;
							byte_acc = inst[22];
							req = 1;
							if (inst[20]) begin
								ld_pend = 1;
								ld_dest = inst[15:12];
								ld_byte = byte_acc;
							end else begin
								wr = 1;
								wdata = read_reg(inst[15:12], pc8);
								if (byte_acc)
									wdata &= 32'hFF;
							end
							done = 1;
						end
						default: begin
							if (!inst[25] && inst[4] && inst[7]) begin
								// Multiply space: only MUL and MLA are supported.
								if (inst[27:22] == 6'd0) begin
									r = read_reg(inst[3:0], pc8) * read_reg(inst[11:8], pc8);
									if (inst[21])
										r += read_reg(inst[15:12], pc8);
									write_reg(inst[19:16], r, next_pc);
									if (inst[20])
										set_nzcv(r, cf, vf);
									done = 1;
								end
							end else begin
								opc = inst[24:21];
								if (opc != OP_BIC) begin
									rn = read_reg(inst[19:16], pc8);
									c = cf;
									v = vf;
									if (inst[25]) begin
										op2 = shifter({24'd0, inst[7:0]}, SH_ROR, inst[11:8] * 2,
											1'b1, cf, sc);
									end else begin
										amt = inst[4] ? read_reg(inst[11:8], pc8) & 32'hFF
											: inst[11:7];
										op2 = shifter(read_reg(inst[3:0], pc8), inst[6:5], amt,
											inst[4], cf, sc);
									end
									case (opc)
										OP_AND, OP_TST: begin r = rn & op2; c = sc; end
										OP_EOR, OP_TEQ: begin r = rn ^ op2; c = sc; end
										OP_SUB, OP_CMP: r = add_carry(rn, ~op2, 1'b1, c, v);
										OP_RSB: r = add_carry(op2, ~rn, 1'b1, c, v);
										OP_ADD, OP_CMN: r = add_carry(rn, op2, 1'b0, c, v);
										OP_ADC: r = add_carry(rn, op2, cf, c, v);
										OP_SBC: r = add_carry(rn, ~op2, cf, c, v);
										OP_RSC: r = add_carry(op2, ~rn, cf, c, v);
										OP_ORR: begin r = rn | op2; c = sc; end
										OP_MOV: begin r = op2; c = sc; end
										default: begin r = ~op2; c = sc; end
									endcase
									if (opc < OP_TST || opc > OP_CMN)
										write_reg(inst[15:12], r, next_pc);
									if (inst[20] || (opc >= OP_TST && opc <= OP_CMN))
										set_nzcv(r, c, v);
									done = 1;
								end
							end
						end
					endcase
				end
			end
			pc = next_pc;
			res.next_fetch_address = pc;
			res.mem_request = req;
			res.mem_is_write = wr;
			res.mem_is_byte = byte_acc;
			res.mem_address = req ? addr : 32'd0;
			res.mem_write_data = wdata;
			res.was_executed = done;
			res.flags_now = nzcv;
			res.is_halted = halted;
			expected_q.push_back(res);
		endfunction

		// Compare one output transaction with the oldest expected result.
		function void check_result(arsie_result_t got);
			arsie_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no expected result pending: %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (got.was_executed)
				executed++;
			if (got.mem_request)
				mem_ops++;
			if (got.next_fetch_address !== e.next_fetch_address) begin
				$error("next_fetch_address: expected %h, got %h", e.next_fetch_address,
					got.next_fetch_address);
				errors++;
			end
			if (got.mem_request !== e.mem_request) begin
				$error("mem_request: expected %b, got %b", e.mem_request, got.mem_request);
				errors++;
			end
			if (got.mem_is_write !== e.mem_is_write) begin
				$error("mem_is_write: expected %b, got %b", e.mem_is_write, got.mem_is_write);
				errors++;
			end
			if (got.mem_is_byte !== e.mem_is_byte) begin
				$error("mem_is_byte: expected %b, got %b", e.mem_is_byte, got.mem_is_byte);
				errors++;
			end
			if (got.mem_address !== e.mem_address) begin
				$error("mem_address: expected %h, got %h", e.mem_address, got.mem_address);
				errors++;
			end
			if (got.mem_write_data !== e.mem_write_data) begin
				$error("mem_write_data: expected %h, got %h", e.mem_write_data,
					got.mem_write_data);
				errors++;
			end
			if (got.was_executed !== e.was_executed) begin
				$error("was_executed: expected %b, got %b", e.was_executed, got.was_executed);
				errors++;
			end
			if (got.flags_now !== e.flags_now) begin
				$error("flags_now: expected %h, got %h", e.flags_now, got.flags_now);
				errors++;
			end
			if (got.is_halted !== e.is_halted) begin
				$error("is_halted: expected %b, got %b", e.is_halted, got.is_halted);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;

	exec_scoreboard sb;
	bit  no_idle;
	int  cycles;
	int  sent;
	int  ready_stall;

	arm_subset_instruction_execute i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Cycle limit for a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Output side: random stalls in bursts.
	always @(negedge clk) begin
		bit rdy;
		rdy = 1'b1;
		if (!no_idle) begin
			if (ready_stall > 0) begin
				ready_stall--;
				rdy = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				ready_stall = $urandom_range(0, 9);
				rdy = 1'b0;
			end
		end
		m_tready <= rdy;
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[$bits(arsie_result_t)-1:0]);
	end

	// Drive one input transaction, optionally after an idle burst.
	task automatic send_item(bit kind, bit [31:0] inst, bit [31:0] ld_word);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = {ld_word, inst};
		do @(posedge clk); while (!s_tready);
		sb.note_input(kind, inst, ld_word);
		sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic run_instr(bit [31:0] inst);
		send_item(1'b0, inst, $urandom);
	endtask

	task automatic wait_drained();
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_start(bit [31:0] addr);
		cfg_wen = 1'b1;
		cfg_wdata = addr;
		@(negedge clk);
		cfg_wen = 1'b0;
		sb.load_start(addr);
	endtask

	function automatic bit [31:0] dp(bit [3:0] cond, bit imm, bit [3:0] opc, bit s, bit [3:0] rn,
			bit [3:0] rd, bit [11:0] op2);
		return {cond, CLS_DP, imm, opc, s, rn, rd, op2};
	endfunction

	function automatic bit [31:0] ls(bit [3:0] cond, bit reg_off, bit up, bit byte_acc, bit load,
			bit [3:0] rn, bit [3:0] rd, bit [11:0] off);
		return {cond, CLS_LS, reg_off, 1'($urandom), up, byte_acc, 1'($urandom), load, rn, rd,
			off};
	endfunction

	function automatic bit [31:0] mul(bit [3:0] cond, bit acc, bit s, bit [3:0] rd, bit [3:0] rn,
			bit [3:0] rs, bit [3:0] rm);
		return {cond, 6'd0, acc, s, rd, rn, rs, 4'b1001, rm};
	endfunction

	// Random instruction, never the halting SWI.
	function automatic bit [31:0] rand_instr();
		bit [31:0] w;
		bit [3:0] cond;
		int sel;
		cond = ($urandom_range(0, 9) < 7) ? COND_AL : 4'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 45)
			w = dp(cond, 1'($urandom), 4'($urandom), 1'($urandom), 4'($urandom),
				4'($urandom_range(0, 15)), 12'($urandom));
		else if (sel < 55)
			w = mul(cond, 1'($urandom), 1'($urandom), 4'($urandom), 4'($urandom),
				4'($urandom), 4'($urandom));
		else if (sel < 63)
			w = {cond, CLS_BR, 1'b1, 1'($urandom), 24'($urandom)};
		else if (sel < 85)
			w = ls(cond, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
				4'($urandom), 12'($urandom));
		else if (sel < 90)
			w = {cond, 4'hF, 24'($urandom)};
		else
			w = $urandom;
		if (w[27:24] == 4'hF && w[7:0] == SWI_HALT)
			w[0] = 1'b1;
		return w;
	endfunction

	initial begin
		bit [31:0] w;
		sb = new();
		cycles = 0;
		sent = 0;
		ready_stall = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: every opcode, flags edge cases, branches, memory access.
		write_start(32'h0000_1000);
		send_item(1'b1, 32'd0, 32'hDEAD_BEEF);                              // data, no load
		run_instr(dp(COND_AL, 1, OP_MOV, 1, 0, 0, 12'h000));                // MOVS zero
		run_instr(dp(COND_AL, 1, OP_MVN, 1, 0, 1, 12'h000));                // R1 = all ones
		run_instr(dp(COND_AL, 1, OP_MOV, 0, 0, 2, 12'h2FF));                // rotated imm
		run_instr(dp(COND_AL, 1, OP_ADD, 1, 2, 3, 12'h1FF));                // overflow path
		run_instr(dp(COND_AL, 0, OP_ADC, 1, 1, 4, {5'd0, SH_LSL, 1'b0, 4'd1}));
		run_instr(dp(COND_AL, 0, OP_SUB, 1, 3, 5, {5'd0, SH_ROR, 1'b0, 4'd1}));  // RRX
		run_instr(dp(COND_AL, 0, OP_RSB, 1, 1, 6, {4'd1, 1'b0, SH_ASR, 1'b1, 4'd3}));
		run_instr(dp(COND_AL, 0, OP_SBC, 1, 15, 7, {5'd0, SH_LSR, 1'b0, 4'd1}));
		run_instr(dp(COND_AL, 1, OP_RSC, 1, 2, 8, 12'h0FF));
		run_instr(dp(COND_AL, 0, OP_AND, 1, 1, 9, {5'd31, SH_LSL, 1'b0, 4'd2}));
		run_instr(dp(COND_AL, 0, OP_EOR, 0, 2, 10, {5'd0, SH_ASR, 1'b0, 4'd1}));
		run_instr(dp(COND_AL, 1, OP_TST, 0, 1, 0, 12'h4FF));                // sets flags anyway
		run_instr(dp(COND_AL, 1, OP_TEQ, 0, 1, 0, 12'h0FF));
		run_instr(dp(COND_AL, 1, OP_CMP, 0, 2, 0, 12'h2FF));                // equal
		run_instr(dp(COND_EQ, 1, OP_ORR, 0, 2, 11, 12'h001));
		run_instr(dp(COND_NE, 1, OP_MOV, 0, 0, 12, 12'h005));               // skipped
		run_instr(dp(4'hF, 1, OP_MOV, 0, 0, 12, 12'h005));                  // never condition
		run_instr(dp(COND_AL, 1, OP_BIC, 1, 1, 12, 12'h0FF));               // unsupported
		run_instr(dp(COND_AL, 1, OP_CMN, 0, 1, 0, 12'h001));
		run_instr(mul(COND_GE, 0, 1, 13, 0, 1, 2));
		run_instr(mul(COND_AL, 1, 1, 13, 3, 2, 1));
		run_instr({COND_AL, CLS_BR, 1'b1, 1'b1, 24'hFFFFFE});               // BL backward
		run_instr(ls(COND_AL, 0, 1, 1, 0, 15, 1, 12'hFFF));                 // STRB
		run_instr(ls(COND_GT, 1, 0, 0, 0, 2, 3, {5'd4, SH_LSL, 1'b0, 4'd1}));
		run_instr(ls(COND_AL, 0, 0, 0, 1, 1, 14, 12'h004));                 // LDR
		send_item(1'b1, 32'd0, 32'h8000_0001);
		run_instr(ls(COND_LE, 0, 1, 1, 1, 0, 15, 12'h000));                 // LDRB into PC
		send_item(1'b1, 32'd0, 32'hFFFF_FF80);
		wait_drained();

		// Random phases over several start addresses.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_start(32'hFFFF_FFFF);
				1: write_start(32'h0000_0000);
				2: write_start($urandom);
				default: write_start(32'h7FFF_FFFC);
			endcase
			if (ph == 3)
				no_idle = 1'b1;
			repeat (385) begin
				w = rand_instr();
				run_instr(w);
				if (w[27:26] == CLS_LS && w[20] ? $urandom_range(0, 9) < 8
						: $urandom_range(0, 19) == 0) begin
					if ($urandom_range(0, 3) == 0)
						run_instr(rand_instr());
					send_item(1'b1, $urandom, $urandom);
				end
			end
			wait_drained();
		end

		// Halt, then items that must be ignored.
		run_instr({COND_AL, 4'hF, 16'($urandom), SWI_HALT});
		run_instr(rand_instr());
		send_item(1'b1, 32'd0, $urandom);
		run_instr(rand_instr());
		wait_drained();

		$display("Sent %0d transactions, checked %0d results (%0d executed, %0d memory ops).",
			sent, sb.checked, sb.executed, sb.mem_ops);
		$display("Covered all ALU opcodes, shifts, conditions, branches, loads, stores, halt.");
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
